/* src/per_bin_welford_background_defines.svh */
// Assertion macros shared by the per-bin background statistics RTL.
// Used by modules that clock on clk and reset on arst_n; no other dependency.
`ifndef PER_BIN_WELFORD_BACKGROUND_DEFINES_SVH
`define PER_BIN_WELFORD_BACKGROUND_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge while reset is released.
`define PBW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks that a trigger is followed in the next cycle by a condition.
`define PBW_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define PBW_ASSERT(name, prop, msg)
`define PBW_ASSERT_NEXT(name, trig, cond, msg)
`endif
`endif

/* src/pbw_pkg.sv */
// Types and constants of the per-bin Welford background statistics block.
// No dependencies; imported by the top level and the testbench.
package pbw_pkg;
	localparam int MAX_BINS    = 4096;
	localparam int BIN_W       = 12;
	localparam int PING_W      = 10;
	localparam int MEAN_W      = 23;
	localparam int SPREAD_W    = 56;
	localparam int STD_W       = 22;
	localparam int ROW_W       = MEAN_W + SPREAD_W;
	localparam int NUM_W       = 25;
	localparam int DIV_STEPS   = NUM_W;
	localparam int RECIP_SHIFT = 38;
	localparam logic [28:0] RECIP_600 = 29'd458129844;
	localparam logic [9:0]  CONST_600 = 10'd600;
	localparam logic [1:0] REG_BINS_PER_PING    = 2'd0;
	localparam logic [1:0] REG_PINGS_TO_AVERAGE = 2'd1;
	localparam logic [12:0] BINS_RESET  = 13'd1024;
	localparam logic [9:0]  PINGS_RESET = 10'd200;

	typedef enum logic [3:0] {
		S_IDLE, S_RECIP, S_CORR, S_DELTA, S_DIV, S_MEAN, S_PROD, S_ACC,
		S_SQA, S_SQB, S_OUT
	} state_t;
endpackage

/* src/pbw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/per_bin_welford_background.sv */
// Top level of the per-bin Welford background statistics block.
// Depends on pbw_pkg, pbw_ram and per_bin_welford_background_defines.svh.
//
//   channel   signals                                              direction
//   cfg       cfg_valid cfg_ready cfg_index cfg_data               write
//   in        in_valid in_ready amplitude_code tvg_correction      sink
//   out       out_valid out_ready bin_index mean_db std_db last_bin source
//
// A sample beat runs through one read of the bin memory, a reciprocal
// multiply for code/300, a restoring divider for the mean update, the M2
// product and the write back.
// On the last ping of a section, when more than one ping was averaged, a
// bit-serial square root follows, with a squaring state and a trial compare per result bit.
// Reset clears state and counters and loads config defaults; the bin memory is not cleared.
// A result held for out_ready does not block the next sample; a later one stalls in S_OUT.
`include "per_bin_welford_background_defines.svh"
module per_bin_welford_background (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] amplitude_code,
	input  logic [19:0] tvg_correction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] bin_index,
	output logic signed [22:0] mean_db,
	output logic [21:0] std_db,
	output logic        last_bin
);
	import pbw_pkg::*;

	// Configuration registers and their effective values.
	logic [12:0] bins_q;
	logic [9:0]  pings_q;
	logic [12:0] nb_eff;
	logic [9:0]  np_eff;

	// Section counters.
	logic [BIN_W-1:0]  bin_cnt_q;
	logic [PING_W-1:0] ping_cnt_q;
	logic              last_b;
	logic              last_ping;
	logic              accept;

	// Per-sample registers.
	logic [15:0]        code_q;
	logic [19:0]        tvg_q;
	logic [BIN_W-1:0]   bin_q;
	logic [10:0]        n_q;
	logic               first_q;
	logic               lastp_q;
	logic               lastb_q;
	logic [28:0]        num600;
	logic [57:0]        recip_q;
	logic [19:0]        q0;
	logic [29:0]        rem600;
	logic [19:0]        qc;
	logic signed [21:0] x_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SPREAD_W-1:0] m2_q;
	logic signed [24:0] delta_q;
	logic signed [24:0] delta_n;
	logic [23:0]        mag;

	// Restoring divider state.
	logic [NUM_W-1:0] num_q;
	logic [11:0]      den_q;
	logic [11:0]      rem_q;
	logic [12:0]      trial;
	logic             qbit;
	logic [4:0]       div_cnt_q;
	logic             div_done;

	// Mean and M2 update.
	logic signed [26:0] qs;
	logic signed [26:0] mean_sum;
	logic signed [MEAN_W-1:0] nm_q;
	logic signed [23:0] diff;
	logic signed [48:0] term_q;
	logic [56:0]        m2_sum;
	logic [SPREAD_W-1:0] m2_new;

	// Square root.
	logic [STD_W-1:0] s_q;
	logic [STD_W-1:0] bit_q;
	logic [STD_W-1:0] t_cand;
	logic [22:0]      t2m1;
	logic [45:0]      sq_q;
	logic [9:0]       k;
	logic [55:0]      kp;
	logic [57:0]      lim;
	logic             sq_done;

	// Memory ports.
	logic             ram_we;
	logic             ram_re;
	logic [ROW_W-1:0] ram_rdata;
	logic             load_out;
	logic             out_valid_q;

	state_t state_q;
	state_t state_n;

	pbw_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bin_q),
		.wdata ({nm_q, m2_new}),
		.re    (ram_re),
		.raddr (bin_cnt_q),
		.rdata (ram_rdata)
	);

	// A register of zero acts as one; bins_per_ping saturates at the memory depth.
	always_comb begin
		if (bins_q == 13'd0) begin
			nb_eff = 13'd1;
		end else if (bins_q > 13'(MAX_BINS)) begin
			nb_eff = 13'(MAX_BINS);
		end else begin
			nb_eff = bins_q;
		end
		np_eff = (pings_q == 10'd0) ? 10'd1 : pings_q;
	end

	// A counter at or past the last index counts as last, which also covers
	// registers lowered in the middle of a section.
	assign last_b    = ({1'b0, bin_cnt_q} + 13'd1) >= nb_eff;
	assign last_ping = ({1'b0, ping_cnt_q} + 11'd1) >= {1'b0, np_eff};
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// code/300 in Q.12 is floor((code*8192 + 300) / 600). The reciprocal
	// product undershoots by at most one, fixed by a single remainder compare.
	assign num600 = {code_q, 13'd0} + 29'd300;
	assign q0     = recip_q[RECIP_SHIFT +: 20];
	assign rem600 = {1'b0, num600} - (30'(q0) * 30'(CONST_600));
	assign qc     = (rem600 >= 30'(CONST_600)) ? q0 + 20'd1 : q0;

	assign delta_n = 25'(x_q) - 25'(mean_q);
	assign mag     = delta_n[24] ? 24'(-delta_n) : 24'(delta_n);

	// One restoring step per cycle; the quotient shifts into num_q.
	assign trial    = {rem_q, num_q[NUM_W-1]};
	assign qbit     = trial >= {1'b0, den_q};
	assign div_done = div_cnt_q == 5'(DIV_STEPS - 1);

	assign qs       = delta_q[24] ? -$signed({2'b0, num_q}) : $signed({2'b0, num_q});
	assign mean_sum = 27'(mean_q) + qs;
	assign diff     = 24'(x_q) - 24'(nm_q);

	// M2 grows only by a positive term and saturates at its full width.
	always_comb begin
		m2_sum = {1'b0, m2_q};
		if (!term_q[48] && (term_q != 49'd0)) begin
			m2_sum = {1'b0, m2_q} + {9'd0, term_q[47:0]};
		end
		m2_new = m2_sum[56] ? {SPREAD_W{1'b1}} : m2_sum[SPREAD_W-1:0];
	end

	// The root is the largest s with (2s-1)^2 * (n-1) <= 4*M2, built from the
	// top bit down; the predicate is monotone so a greedy trial is exact.
	assign t_cand  = s_q | bit_q;
	assign t2m1    = {t_cand, 1'b0} - 23'd1;
	assign k       = 10'(n_q - 11'd1);
	assign kp      = sq_q * k;
	assign lim     = {m2_q, 2'b00};
	assign sq_done = bit_q[0];

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = S_RECIP;
				end
			end
			S_RECIP: state_n = S_CORR;
			S_CORR:  state_n = S_DELTA;
			S_DELTA: state_n = S_DIV;
			S_DIV: begin
				if (div_done) begin
					state_n = S_MEAN;
				end
			end
			S_MEAN: state_n = S_PROD;
			S_PROD: state_n = S_ACC;
			S_ACC: begin
				if (!lastp_q) begin
					state_n = S_IDLE;
				end else if (n_q > 11'd1) begin
					state_n = S_SQA;
				end else begin
					state_n = S_OUT;
				end
			end
			S_SQA: state_n = S_SQB;
			S_SQB:   state_n = sq_done ? S_OUT : S_SQA;
			S_OUT: begin
				if (load_out) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_valid;
			end
			S_ACC:   ram_we = 1'b1;
			S_OUT:   load_out = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bins_q      <= BINS_RESET;
			pings_q     <= PINGS_RESET;
			bin_cnt_q   <= '0;
			ping_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BINS_PER_PING) begin
					bins_q <= cfg_data[12:0];
				end else if (cfg_index == REG_PINGS_TO_AVERAGE) begin
					pings_q <= cfg_data[9:0];
				end
			end
			if (accept) begin
				if (last_b) begin
					bin_cnt_q  <= '0;
					ping_cnt_q <= last_ping ? '0 : ping_cnt_q + 10'd1;
				end else begin
					bin_cnt_q <= bin_cnt_q + 12'd1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					code_q  <= amplitude_code;
					tvg_q   <= tvg_correction;
					bin_q   <= bin_cnt_q;
					n_q     <= {1'b0, ping_cnt_q} + 11'd1;
					first_q <= ping_cnt_q == '0;
					lastp_q <= last_ping;
					lastb_q <= last_b;
				end
			end
			S_RECIP: begin
				recip_q <= num600 * RECIP_600;
				// The first ping of a section restarts from zero.
				mean_q  <= first_q ? '0 : $signed(ram_rdata[ROW_W-1:SPREAD_W]);
				m2_q    <= first_q ? '0 : ram_rdata[SPREAD_W-1:0];
			end
			S_CORR: begin
				x_q <= $signed({2'b00, tvg_q}) - $signed({2'b00, qc});
			end
			S_DELTA: begin
				delta_q   <= delta_n;
				num_q     <= {mag, 1'b0} + {14'd0, n_q};
				den_q     <= {n_q, 1'b0};
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			S_DIV: begin
				rem_q     <= qbit ? 12'(trial - {1'b0, den_q}) : trial[11:0];
				num_q     <= {num_q[NUM_W-2:0], qbit};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			S_MEAN: begin
				if (mean_sum > 27'sd4194303) begin
					nm_q <= 23'sd4194303;
				end else if (mean_sum < -27'sd4194304) begin
					nm_q <= -23'sd4194304;
				end else begin
					nm_q <= mean_sum[MEAN_W-1:0];
				end
			end
			S_PROD: begin
				term_q <= delta_q * diff;
			end
			S_ACC: begin
				m2_q  <= m2_new;
				s_q   <= '0;
				bit_q <= {1'b1, {(STD_W-1){1'b0}}};
			end
			S_SQA: begin
				sq_q <= t2m1 * t2m1;
			end
			S_SQB: begin
				if ({2'b00, kp} <= lim) begin
					s_q <= t_cand;
				end
				bit_q <= bit_q >> 1;
			end
			S_OUT: begin
				if (load_out) begin
					bin_index <= bin_q;
					mean_db   <= nm_q;
					std_db    <= s_q;
					last_bin  <= lastb_q;
				end
			end
			default: begin
				code_q <= code_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`PBW_ASSERT_NEXT(a_accept_starts_read, accept, state_q == S_RECIP, "accept did not start a read")
	`PBW_ASSERT_NEXT(a_bin_wraps, accept && last_b, bin_cnt_q == '0, "bin counter did not wrap")
	`PBW_ASSERT(a_sqrt_onehot, (state_q == S_SQA || state_q == S_SQB) |-> $onehot(bit_q), "root bit")
	`PBW_ASSERT(a_div_range, state_q == S_DIV |-> div_cnt_q < 5'(DIV_STEPS), "divider overran")
endmodule

/* tb/pbw_stats_checker.sv */
`timescale 1ns / 100ps
// Predicts and checks the per-bin Welford background statistics block.
// Depends on pbw_pkg; watches the cfg, in and out channels of the block.
module pbw_stats_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [15:0]       amplitude_code,
	input  logic [19:0]       tvg_correction,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [11:0]       bin_index,
	input  logic signed [22:0] mean_db,
	input  logic [21:0]       std_db,
	input  logic              last_bin,
	output int                mismatches,
	output int                stats_due,
	output logic              mid_section
);
	import pbw_pkg::*;

	typedef struct packed {
		logic [11:0] bin;
		logic [22:0] mean;
		logic [21:0] std;
		logic        last;
	} bin_stats_t;

	bin_stats_t  expected_stats[$];
	logic [12:0] bins_reg;
	logic [9:0]  pings_reg;
	int unsigned bin_cnt;
	int unsigned ping_cnt;
	longint      mean_mem[MAX_BINS];
	logic [63:0] m2_mem[MAX_BINS];

	localparam longint MEAN_HI = 4194303;
	localparam longint MEAN_LO = -4194304;
	localparam logic [63:0] M2_HI = (64'd1 << 56) - 64'd1;

	assign stats_due   = expected_stats.size();
	assign mid_section = (bin_cnt != 0) || (ping_cnt != 0);

	function automatic longint rounded_quotient(input longint d, input int unsigned n);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (d < 0) ? -d : d;
		q = (mag * 2 + n) / (2 * 64'(n));
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Largest s with (2s-1)^2 * k <= 4*m2, i.e. sqrt(m2/k) rounded, ties up.
	function automatic logic [21:0] rounded_std(input logic [63:0] m2, input int unsigned k);
		logic [63:0] lim;
		logic [63:0] t;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lim = m2 << 2;
		lo = 0;
		hi = 4194303;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 64'(mid) * 2 - 1;
			if (t * t * 64'(k) <= lim)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[21:0];
	endfunction

	task automatic fold_sample(input logic [15:0] code, input logic [19:0] tvg);
		int unsigned nb;
		int unsigned np;
		int unsigned b;
		int unsigned n;
		logic        last_b;
		logic        last_p;
		longint      x;
		longint      mean;
		longint      delta;
		longint      nm;
		longint      term;
		logic [63:0] m2;
		bin_stats_t  s;
		nb = (bins_reg == 0) ? 1 : bins_reg;
		np = (pings_reg == 0) ? 1 : pings_reg;
		if (nb > MAX_BINS) nb = MAX_BINS;
		if (np > 1023) np = 1023;
		b = bin_cnt % MAX_BINS;
		last_b = (bin_cnt + 1 >= nb);
		last_p = (ping_cnt + 1 >= np);
		n = ping_cnt + 1;
		x = longint'(tvg) - longint'((64'(code) * 8192 + 300) / 600);
		// The first ping of a section starts the bin afresh.
		mean = (ping_cnt == 0) ? 0 : mean_mem[b];
		m2 = (ping_cnt == 0) ? 64'd0 : m2_mem[b];
		delta = x - mean;
		nm = mean + rounded_quotient(delta, n);
		if (nm > MEAN_HI) nm = MEAN_HI;
		if (nm < MEAN_LO) nm = MEAN_LO;
		term = delta * (x - nm);
		if (term > 0) begin
			if (64'(term) > M2_HI - m2)
				m2 = M2_HI;
			else
				m2 = m2 + 64'(term);
		end
		mean_mem[b] = nm;
		m2_mem[b] = m2;
		if (last_p) begin
			s.bin = b[11:0];
			s.mean = nm[22:0];
			s.std = (n > 1) ? rounded_std(m2, n - 1) : '0;
			s.last = last_b;
			expected_stats.push_back(s);
		end
		if (last_b) begin
			bin_cnt = 0;
			ping_cnt = last_p ? 0 : ((ping_cnt + 1) & 32'h3FF);
		end else begin
			bin_cnt = (bin_cnt + 1) & 32'hFFF;
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_BINS; i++) begin
			mean_mem[i] = 0;
			m2_mem[i] = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		bin_stats_t e;
		if (!arst_n) begin
			bins_reg = BINS_RESET;
			pings_reg = PINGS_RESET;
			bin_cnt = 0;
			ping_cnt = 0;
			mismatches = 0;
			expected_stats.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BINS_PER_PING)
					bins_reg = cfg_data[12:0];
				else if (cfg_index == REG_PINGS_TO_AVERAGE)
					pings_reg = cfg_data[9:0];
			end
			if (in_valid && in_ready)
				fold_sample(amplitude_code, tvg_correction);
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result beat bin %0d", $realtime, bin_index);
				end else begin
					e = expected_stats.pop_front();
					if (e.bin !== bin_index || e.mean !== mean_db || e.std !== std_db ||
							e.last !== last_bin) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: result mismatch exp bin %0d mean %0d std %0d",
								" last %0d, got bin %0d mean %0d std %0d last %0d"},
								$realtime, e.bin, $signed(e.mean), e.std, e.last,
								bin_index, mean_db, std_db, last_bin);
					end
				end
			end
		end
	end
endmodule

/* tb/tb_per_bin_welford_background.sv */
`timescale 1ns / 100ps
// Top of the testbench for the per-bin Welford background statistics block.
// Depends on pbw_pkg, per_bin_welford_background and pbw_stats_checker.
module tb_per_bin_welford_background;
	import pbw_pkg::*;

	// Generous ceiling on the whole run; the slowest legal run is far below it.
	localparam int CYCLE_LIMIT = 3000000;
	// Quiet time after the last result, well beyond one sample plus square root.
	localparam int SETTLE = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_BINS_PER_PING;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] amplitude_code = '0;
	logic [19:0] tvg_correction = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [11:0] bin_index;
	logic signed [22:0] mean_db;
	logic [21:0] std_db;
	logic last_bin;

	int mismatches;
	int stats_due;
	logic mid_section;
	int cycles = 0;
	int samples_sent = 0;
	// While set, neither side inserts idle cycles.
	logic calm = 1'b0;
	// Effective register values as the block sees them, after clamping.
	int unsigned eff_bins = 1024;
	int unsigned eff_pings = 200;

	always #5 clk = ~clk;

	per_bin_welford_background dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .amplitude_code(amplitude_code),
		.tvg_correction(tvg_correction),
		.out_valid(out_valid), .out_ready(out_ready), .bin_index(bin_index),
		.mean_db(mean_db), .std_db(std_db), .last_bin(last_bin)
	);

	pbw_stats_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .amplitude_code(amplitude_code),
		.tvg_correction(tvg_correction),
		.out_valid(out_valid), .out_ready(out_ready), .bin_index(bin_index),
		.mean_db(mean_db), .std_db(std_db), .last_bin(last_bin),
		.mismatches(mismatches), .stats_due(stats_due), .mid_section(mid_section)
	);

	// Unless calm is set, the receiver drops out_ready at random with a six percent chance.
	always @(posedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Writes one register. cfg_valid is lowered and the task returns after the
	// next rising edge, so the next write never lowers and raises it in the same step.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		// Ready is stable between the falling and the next rising edge.
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BINS_PER_PING) begin
			eff_bins = (value[12:0] == 0) ? 1 : value[12:0];
			if (eff_bins > MAX_BINS) eff_bins = MAX_BINS;
		end else begin
			eff_pings = (value[9:0] == 0) ? 1 : value[9:0];
		end
		@(posedge clk);
	endtask

	// Sends one sample beat. in_valid stays high afterwards so back-to-back
	// beats need no toggle; it only drops in an idle gap or a drain.
	task automatic put_sample(input logic [15:0] code, input logic [19:0] tvg);
		if (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		in_valid <= 1'b1;
		amplitude_code <= code;
		tvg_correction <= tvg;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		samples_sent++;
	endtask

	// Sender pauses until every expected result is out, then lets any sample
	// that yields no result finish inside the block.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (stats_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_code();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [19:0] rand_tvg();
		case ($urandom_range(7))
			0: return 20'h00000;
			1: return 20'hFFFFF;
			default: return 20'($urandom_range(0, 1048575));
		endcase
	endfunction

	initial begin
		int phase;
		int unsigned span;
		int unsigned n_items;
		int unsigned r;
		logic [15:0] value;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: a few beats of the first ping give no result.
		put_sample(16'h0000, 20'h00000);
		put_sample(16'hFFFF, 20'hFFFFF);
		put_sample(16'h0000, 20'hFFFFF);
		drain();
		// Zero in both registers acts as one. The bin counter now sits past the
		// new last bin and the ping counter at the last ping, so the next beat
		// closes the section with a single-ping result whose deviation is reported as zero.
		write_reg(REG_PINGS_TO_AVERAGE, 16'd0);
		write_reg(REG_BINS_PER_PING, 16'hE000);
		put_sample(16'hFFFF, 20'h00000);
		drain();

		// Two bins and the largest averaging depth, then the depth is lowered
		// mid-section: the fourth ping becomes the last and reports n = 4.
		write_reg(REG_BINS_PER_PING, 16'd2);
		write_reg(REG_PINGS_TO_AVERAGE, 16'd1023);
		for (int i = 0; i < 6; i++)
			put_sample((i % 2) ? 16'hFFFF : 16'h0000, (i % 4 < 2) ? 20'hFFFFF : 20'h00000);
		drain();
		write_reg(REG_PINGS_TO_AVERAGE, 16'd2);
		put_sample(16'h0000, 20'hFFFFF);
		put_sample(16'hFFFF, 20'h00000);
		drain();

		// Oversized bin count saturates to the maximum; lowering it mid-ping
		// wraps the bin counter on the next beat.
		write_reg(REG_BINS_PER_PING, 16'h1FFF);
		write_reg(REG_PINGS_TO_AVERAGE, 16'd1);
		for (int i = 0; i < 4; i++)
			put_sample(rand_code(), rand_tvg());
		drain();
		write_reg(REG_BINS_PER_PING, 16'd3);
		put_sample(16'h1234, 20'h54321);
		drain();

		// Random sections. Only a section boundary may raise the bin count;
		// mid-section the bin count is never raised, so no unwritten bin is
		// ever read back.
		phase = 0;
		while (samples_sent < 1070) begin
			calm = (phase >= 12 && phase < 18);
			if (!mid_section) begin
				r = $urandom_range(99);
				if (r < 5)
					value = 16'd0;
				else if (r < 15)
					value = 16'($urandom_range(9, 40));
				else
					value = 16'($urandom_range(1, 8));
				value[15:13] = 3'($urandom_range(0, 7));
				write_reg(REG_BINS_PER_PING, value);
				r = $urandom_range(99);
				if (r < 5)
					value = 16'd0;
				else if (r < 9)
					value = 16'd1023;
				else if (r < 20)
					value = 16'($urandom_range(6, 12));
				else
					value = 16'($urandom_range(1, 5));
				value[15:10] = 6'($urandom_range(0, 63));
				write_reg(REG_PINGS_TO_AVERAGE, value);
			end else if ($urandom_range(1)) begin
				write_reg(REG_BINS_PER_PING, 16'($urandom_range(1, eff_bins)));
			end else begin
				write_reg(REG_PINGS_TO_AVERAGE, 16'($urandom_range(0, 8)));
			end
			span = eff_bins * eff_pings;
			n_items = (span <= 60) ? span * $urandom_range(1, 2) : $urandom_range(10, 60);
			if ($urandom_range(3) == 0)
				n_items += $urandom_range(1, eff_bins);
			if (n_items > 150) n_items = 150;
			for (int i = 0; i < n_items; i++)
				put_sample(rand_code(), rand_tvg());
			drain();
			phase++;
		end

		if (mismatches == 0 && stats_due == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
